/* src/cba_pkg.sv */
// Shared constants and types for the clamped block average.
// Used by cba_divider, clamped_block_average and the bench; no dependencies.
`timescale 1ns / 1ps

package cba_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int OUT_W      = 12;
    localparam int CNT_W      = 13;
    localparam int SUM_W      = 24;
    localparam int DIV_CNT_W  = $clog2(SUM_W);
    localparam int MAX_PERIOD = 4096;
    localparam int SAMPLE_MAX = 4095;
    localparam int PERIOD_RST = 10;

    // Status of the shared divider as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

/* src/cba_divider.sv */
// Restoring divider, one quotient bit per cycle, for the block average.
// Depends on cba_pkg.
`timescale 1ns / 1ps

module cba_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [cba_pkg::SUM_W-1:0]  dividend,
    input  logic [cba_pkg::CNT_W-1:0]  divisor,
    output cba_pkg::div_status_t       status,
    output logic [cba_pkg::OUT_W-1:0]  quotient
);

    localparam logic [cba_pkg::DIV_CNT_W-1:0] LAST_STEP =
        cba_pkg::DIV_CNT_W'(cba_pkg::SUM_W - 1);

    logic                           busy_reg;
    logic                           done_reg;
    logic [cba_pkg::DIV_CNT_W-1:0]  step_reg;
    logic [cba_pkg::SUM_W-1:0]      dq_reg;
    logic [cba_pkg::SUM_W-1:0]      dq_next;
    logic [cba_pkg::CNT_W-1:0]      rem_reg;
    logic [cba_pkg::CNT_W-1:0]      rem_next;
    logic [cba_pkg::CNT_W-1:0]      den_reg;
    logic [cba_pkg::CNT_W:0]        rem_shift;
    logic [cba_pkg::CNT_W:0]        rem_diff;
    logic                           fits;

    // The dividend register shifts out at the top while quotient bits enter
    // at the bottom, so after the last step it holds the quotient.
    always_comb
    begin
        rem_shift = {rem_reg, dq_reg[cba_pkg::SUM_W-1]};
        rem_diff  = rem_shift - {1'b0, den_reg};
        fits      = (rem_shift >= {1'b0, den_reg});
        rem_next  = fits ? rem_diff[cba_pkg::CNT_W-1:0] : rem_shift[cba_pkg::CNT_W-1:0];
        dq_next   = {dq_reg[cba_pkg::SUM_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dq_reg  <= dq_next;
            rem_reg <= rem_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = dq_reg[cba_pkg::OUT_W-1:0];

endmodule

/* src/clamped_block_average.sv */
// Clamped block average decimator: top level with sequencer and accumulator.
// Depends on cba_pkg and cba_divider.
//
// Usage: each sample request on s_* carries one signed 16-bit converter reading.
// It is clamped to 0..4095 and added to a running sum. When the sample count
// reaches the period length (cfg port, reset value 10, zero acts as one,
// values above 4096 act as 4096), the rounded average (sum + n/2) / n goes
// out on m_*, and the sum and count restart from zero.
// Samples that do not close a period can be taken back to back. A closing
// sample starts the shared bit-serial divider, which runs 24 steps; the
// quotient then goes from the divide state to the hold state, which loads it
// into the output register on m_*. s_tready stays low from the closing request
// until that load.
// A pending result waits in the output register while further non-closing
// samples are taken; if the next period ends before the receiver takes it, the
// new quotient is held in the divider and s_tready stays low until m_tready
// frees the output register.
// Reset clears the sum, the count and any pending result and sets the period
// to 10. Configuration is always ready and meant to be written while idle.
`timescale 1ns / 1ps

module clamped_block_average (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,     // [15:0] raw_sample (signed)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // [11:0] avg_light, [15:12] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_data     // [12:0] period_len
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    localparam logic [cba_pkg::CNT_W-1:0] PERIOD_MAX =
        cba_pkg::CNT_W'(cba_pkg::MAX_PERIOD);
    localparam logic [cba_pkg::OUT_W-1:0] CLAMP_MAX =
        cba_pkg::OUT_W'(cba_pkg::SAMPLE_MAX);

    logic [1:0]                    state_reg;
    logic [1:0]                    state_next;
    logic [cba_pkg::CNT_W-1:0]     period_reg;
    logic [cba_pkg::SUM_W-1:0]     sum_reg;
    logic [cba_pkg::SUM_W-1:0]     sum_next;
    logic [cba_pkg::CNT_W-1:0]     count_reg;
    logic [cba_pkg::CNT_W-1:0]     count_next;
    logic                          out_valid_reg;
    logic [cba_pkg::OUT_W-1:0]     out_data_reg;

    logic signed [cba_pkg::SAMPLE_W-1:0] raw;
    logic [cba_pkg::OUT_W-1:0]     clamped;
    logic [cba_pkg::CNT_W-1:0]     eff_period;
    logic                          s_fire;
    logic                          closes;
    logic                          out_free;
    logic                          load_out;
    logic [cba_pkg::SUM_W-1:0]     dividend;
    cba_pkg::div_status_t          div_status;
    logic [cba_pkg::OUT_W-1:0]     quotient;

    assign raw       = s_tdata;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;

    always_comb
    begin
        if (raw < 0)
            clamped = '0;
        else if (raw > $signed({1'b0, CLAMP_MAX}))
            clamped = CLAMP_MAX;
        else
            clamped = raw[cba_pkg::OUT_W-1:0];

        if (period_reg == '0)
            eff_period = cba_pkg::CNT_W'(1);
        else if (period_reg > PERIOD_MAX)
            eff_period = PERIOD_MAX;
        else
            eff_period = period_reg;

        sum_next   = sum_reg + {{(cba_pkg::SUM_W-cba_pkg::OUT_W){1'b0}}, clamped};
        count_next = count_reg + 1'b1;
        closes     = (count_next >= eff_period);
        // Adding half the count first turns the floor division into round half up.
        dividend   = sum_next + {{(cba_pkg::SUM_W-cba_pkg::CNT_W){1'b0}}, count_next >> 1};
    end

    cba_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (s_fire && closes),
        .dividend (dividend),
        .divisor  (count_next),
        .status   (div_status),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next = state_reg;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire && closes)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_status.done)
                    state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            period_reg    <= cba_pkg::CNT_W'(cba_pkg::PERIOD_RST);
            sum_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                period_reg <= cfg_data;
            if (s_fire)
            begin
                sum_reg   <= closes ? '0 : sum_next;
                count_reg <= closes ? '0 : count_next;
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            out_data_reg <= quotient;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(16-cba_pkg::OUT_W){1'b0}}, out_data_reg};

`ifndef SYNTHESIS
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.busy |-> !s_tready)
        else $error("input request accepted while the divider runs");

    a_close_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && closes) |=> (div_status.busy && state_reg == ST_DIV))
        else $error("closing sample did not start the divider");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < PERIOD_MAX)
        else $error("sample count reached the maximum period without closing");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> out_free)
        else $error("output register overwritten while its result waits");
`endif

endmodule

/* bench/block_average_checker.sv */
// Checker for the clamped block average: watches the sample, result and config channels.
// Keeps its own running sum and count to predict each period average, then compares.
// Depends on cba_pkg.
`timescale 1ns / 1ps

module block_average_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [15:0]               s_tdata,     // [15:0] raw_sample (signed)
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [15:0]               m_tdata,     // [11:0] avg_light, [15:12] zero
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [cba_pkg::CNT_W-1:0] cfg_data,    // [12:0] period_len
    output int                        mismatches,
    output int                        outstanding
);

    logic [cba_pkg::CNT_W-1:0] period_q;
    logic [cba_pkg::SUM_W-1:0] sum_q;
    logic [cba_pkg::CNT_W-1:0] count_q;
    logic [cba_pkg::CNT_W-1:0] next_count;
    logic [cba_pkg::SUM_W-1:0] next_sum;
    logic [cba_pkg::OUT_W-1:0] want;
    logic [cba_pkg::OUT_W-1:0] expected_avg [$];

    function automatic logic [cba_pkg::SAMPLE_W-1:0] clamp_reading(
        input logic signed [cba_pkg::SAMPLE_W-1:0] raw);
        if (raw < 0)
            return '0;
        if (raw > cba_pkg::SAMPLE_MAX)
            return cba_pkg::SAMPLE_W'(cba_pkg::SAMPLE_MAX);
        return raw;
    endfunction

    function automatic logic [cba_pkg::CNT_W-1:0] effective_period(
        input logic [cba_pkg::CNT_W-1:0] p);
        if (p == 0)
            return cba_pkg::CNT_W'(1);
        if (p > cba_pkg::MAX_PERIOD)
            return cba_pkg::CNT_W'(cba_pkg::MAX_PERIOD);
        return p;
    endfunction

    // Round half up: add half the count before the integer divide.
    function automatic logic [cba_pkg::OUT_W-1:0] rounded_block_mean(
        input logic [cba_pkg::SUM_W-1:0] total,
        input logic [cba_pkg::CNT_W-1:0] n);
        logic [cba_pkg::SUM_W:0] num;
        logic [cba_pkg::SUM_W:0] quo;
        num = total + (n >> 1);
        quo = num / n;
        return quo[cba_pkg::OUT_W-1:0];
    endfunction

    task automatic flag_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatches = mismatches + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_q = cba_pkg::CNT_W'(cba_pkg::PERIOD_RST);
            sum_q = '0;
            count_q = '0;
            expected_avg.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                period_q = cfg_data;

            if (m_tvalid && m_tready)
            begin
                if (expected_avg.size() == 0)
                    flag_mismatch($sformatf("average %0d with none pending",
                                            m_tdata[cba_pkg::OUT_W-1:0]));
                else
                begin
                    want = expected_avg.pop_front();
                    if (m_tdata[cba_pkg::OUT_W-1:0] !== want)
                        flag_mismatch($sformatf("avg_light %0d, expected %0d",
                                                m_tdata[cba_pkg::OUT_W-1:0], want));
                    if (m_tdata[15:cba_pkg::OUT_W] !== '0)
                        flag_mismatch($sformatf("pad bits of m_tdata are %h",
                                                m_tdata[15:cba_pkg::OUT_W]));
                end
            end

            if (s_tvalid && s_tready)
            begin
                next_count = count_q + 1'b1;
                next_sum = sum_q + clamp_reading(s_tdata);
                // A shortened period closes on the first sample that reaches or passes it.
                if (next_count >= effective_period(period_q))
                begin
                    expected_avg.push_back(rounded_block_mean(next_sum, next_count));
                    sum_q = '0;
                    count_q = '0;
                end
                else
                begin
                    sum_q = next_sum;
                    count_q = next_count;
                end
            end

            outstanding = expected_avg.size();
        end
    end

endmodule

/* bench/tb.sv */
// Top of the clamped block average bench: clock, reset, sample and config stimulus, verdict.
// Depends on cba_pkg, clamped_block_average and block_average_checker.
`timescale 1ns / 1ps

module tb;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [15:0]               s_tdata = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [15:0]               m_tdata;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [cba_pkg::CNT_W-1:0] cfg_data = '0;
    int                        mismatches;
    int                        outstanding;
    bit                        tx_burst = 1'b0;
    bit                        rx_burst = 1'b0;
    int                        fed = 0;

    always #5 clk = ~clk;

    clamped_block_average dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    block_average_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // In-range readings as the largest share, with plenty of negatives, overranges and corners.
    function automatic logic [15:0] draw_reading();
        logic [15:0] corner [0:7] = '{16'h0000, 16'h0001, 16'h0FFE, 16'h0FFF,
                                      16'h1000, 16'hFFFF, 16'h8000, 16'h7FFF};
        case ($urandom_range(0, 7))
            0, 1:    return 16'($urandom);
            2, 3, 4: return 16'($urandom_range(0, cba_pkg::SAMPLE_MAX));
            5:       return corner[$urandom_range(0, 7)];
            6:       return 16'($urandom_range(cba_pkg::SAMPLE_MAX + 1, 32767));
            default: return 16'h8000 | 16'($urandom_range(0, 32767));
        endcase
    endfunction

    // All tasks start and end just after a falling edge.
    task automatic push_reading(input logic [15:0] v);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= v;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic settle(input int tail);
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (tail) @(negedge clk);
    endtask

    // Wait until no average is pending and the block has gone idle before a write.
    task automatic write_period(input logic [cba_pkg::CNT_W-1:0] p);
        settle(30);
        cfg_valid <= 1'b1;
        cfg_data <= p;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : receiver
        int stall;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = rx_burst ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        logic [15:0]               first_period [0:9] = '{16'h8000, 16'h7FFF, 16'h0000,
                                                          16'h0FFF, 16'h1000, 16'hFFFF,
                                                          16'h0001, 16'h0800, 16'h0FFF,
                                                          16'h1000};
        logic [15:0]               pass_through [0:4] = '{16'h8000, 16'h7FFF, 16'h0FFF,
                                                          16'h1000, 16'h0001};
        logic [cba_pkg::CNT_W-1:0] p;
        int                        n;
        int                        cut;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset period of ten, with every clamp corner in it.
        foreach (first_period[i])
            push_reading(first_period[i]);

        // Zero acts as one: each reading comes back clamped.
        write_period('0);
        foreach (pass_through[i])
            push_reading(pass_through[i]);

        // Pairs that tie exactly, which must round up.
        write_period(cba_pkg::CNT_W'(2));
        push_reading(16'h0000);
        push_reading(16'h0001);
        push_reading(16'h0FFF);
        push_reading(16'h0FFE);

        // Shorten the period under a partly filled one.
        write_period(cba_pkg::CNT_W'(8));
        repeat (5) push_reading(draw_reading());
        write_period(cba_pkg::CNT_W'(3));
        push_reading(draw_reading());

        // The largest setting must not close early; a long run of readings near the top
        // is then closed by shortening the period.
        tx_burst = 1'b1;
        write_period('1);
        repeat (200)
            push_reading(($urandom_range(0, 3) == 0) ? draw_reading() : 16'h7FFF);
        write_period(cba_pkg::CNT_W'(3));
        push_reading(draw_reading());

        while (fed < 1075)
        begin
            case ($urandom_range(0, 19))
                0, 1:             p = '0;
                2, 3:             p = cba_pkg::CNT_W'(1);
                4, 5, 6, 7, 8,
                9, 10, 11, 12, 13: p = cba_pkg::CNT_W'($urandom_range(2, 12));
                14, 15, 16, 17:   p = cba_pkg::CNT_W'($urandom_range(13, 64));
                default:          p = cba_pkg::CNT_W'($urandom_range(65, 300));
            endcase
            // Sometimes keep the old period so partial periods run across phases.
            if ($urandom_range(0, 7) != 0)
                write_period(p);
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            n = $urandom_range(1, 50);
            cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, n) : 0;
            for (int i = 1; i <= n; i++)
            begin
                push_reading(draw_reading());
                fed++;
                // Hold further requests until every pending average is out.
                if (i == cut)
                    settle(1);
            end
        end

        settle(40);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
